// ----- rtl/assert_macros.svh -----
// assertion macros shared by the deque rtl
// no dependencies; each macro expects clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define CDQ_ASSERT_IMPL(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define CDQ_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ----- rtl/cdq_pkg.sv -----
// types, constants and index helpers for the circular deque
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package cdq_pkg;

  localparam int DEPTH  = 16;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W = $clog2(DEPTH + 1);
  localparam int WORD_W = 32;
  localparam int CNT_W  = 5;

  localparam logic [1:0] OP_PUSH_BACK  = 2'd0;
  localparam logic [1:0] OP_POP_BACK   = 2'd1;
  localparam logic [1:0] OP_PUSH_FRONT = 2'd2;
  localparam logic [1:0] OP_POP_FRONT  = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]               op;
    logic signed [WORD_W-1:0] data_in;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] data_out;
    logic [1:0]               status;
    logic [CNT_W-1:0]         count;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
  } dp_cmd_t;

  function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] prev_slot(input logic [IDX_W-1:0] i);
    return (i == '0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
  endfunction

  // fill level folded into the 5-bit count field
  function automatic logic [CNT_W-1:0] fill_to_count(input logic [FILL_W-1:0] f);
    logic [CNT_W+FILL_W-1:0] w;
    w = {{CNT_W{1'b0}}, f};
    return w[CNT_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/cdq_ctrl.sv -----
// handshake controller for the circular deque
// depends on cdq_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none

module cdq_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output cdq_pkg::dp_cmd_t     cmd
);
  import cdq_pkg::*;
  `include "assert_macros.svh"

  localparam logic S_IDLE = 1'b0;
  localparam logic S_HOLD = 1'b1;

  logic state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_HOLD;
      end
      S_HOLD: begin
        if (!out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall   = (state_r == S_HOLD);
  assign out_valid  = (state_r == S_HOLD);
  assign cmd.accept = in_valid && !in_stall;

  `CDQ_ASSERT_NEXT(a_accept_gives_result, cmd.accept, out_valid, "no result after request")
  `CDQ_ASSERT_NEXT(a_result_held, out_valid && out_stall, out_valid, "stalled result dropped")
  `CDQ_ASSERT_NEXT(a_taken_clears, out_valid && !out_stall, !out_valid, "result repeated")

endmodule

`default_nettype wire

// ----- rtl/cdq_datapath.sv -----
// indices, fill level, circular store and result registers of the deque
// depends on cdq_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none

module cdq_datapath (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cdq_pkg::dp_cmd_t   cmd,
  input  wire cdq_pkg::in_item_t  in_item,
  output cdq_pkg::out_item_t      out_item
);
  import cdq_pkg::*;
  `include "assert_macros.svh"

  logic signed [WORD_W-1:0] mem [DEPTH];

  logic [IDX_W-1:0]  front_r, front_nxt;
  logic [IDX_W-1:0]  back_r, back_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [1:0]        status_r, status_nxt;
  logic [CNT_W-1:0]  count_r;
  logic              pop_ok_r, pop_ok_nxt;
  logic signed [WORD_W-1:0] rd_r;

  logic             full, empty, is_push;
  logic             wr_en, rd_en;
  logic [IDX_W-1:0] wr_addr, rd_addr;

  assign full    = (fill_r == FILL_W'(DEPTH));
  assign empty   = (fill_r == '0);
  assign is_push = (in_item.op == OP_PUSH_BACK) || (in_item.op == OP_PUSH_FRONT);

  always_comb begin
    front_nxt  = front_r;
    back_nxt   = back_r;
    fill_nxt   = fill_r;
    status_nxt = ST_OK;
    pop_ok_nxt = 1'b0;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    wr_addr    = back_r;
    rd_addr    = front_r;
    case (in_item.op)
      OP_PUSH_BACK: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          wr_en    = cmd.accept;
          wr_addr  = back_r;
          back_nxt = next_slot(back_r);
          fill_nxt = fill_r + 1'b1;
        end
      end
      OP_PUSH_FRONT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          wr_en     = cmd.accept;
          wr_addr   = prev_slot(front_r);
          front_nxt = prev_slot(front_r);
          fill_nxt  = fill_r + 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          rd_en      = cmd.accept;
          rd_addr    = prev_slot(back_r);
          back_nxt   = prev_slot(back_r);
          fill_nxt   = fill_r - 1'b1;
          pop_ok_nxt = 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          rd_en      = cmd.accept;
          rd_addr    = front_r;
          front_nxt  = next_slot(front_r);
          fill_nxt   = fill_r - 1'b1;
          pop_ok_nxt = 1'b1;
        end
      end
      default: status_nxt = ST_OK;
    endcase
  end

  // store: one write or one registered read per request
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= in_item.data_in;
    if (rd_en) rd_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r  <= '0;
      back_r   <= '0;
      fill_r   <= '0;
      pop_ok_r <= 1'b0;
    end else if (cmd.accept) begin
      front_r  <= front_nxt;
      back_r   <= back_nxt;
      fill_r   <= fill_nxt;
      pop_ok_r <= pop_ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      status_r <= status_nxt;
      count_r  <= fill_to_count(fill_nxt);
    end
  end

  assign out_item.data_out = pop_ok_r ? rd_r : '0;
  assign out_item.status   = status_r;
  assign out_item.count    = count_r;

  `CDQ_ASSERT_IMPL(a_fill_bound, 1'b1, fill_r <= FILL_W'(DEPTH), "fill level beyond depth")
  `CDQ_ASSERT_NEXT(a_full_push_keeps, cmd.accept && is_push && full, $stable(fill_r),
    "push while full changed the fill level")

endmodule

`default_nettype wire

// ----- rtl/circular_double_ended_queue_unit.sv -----
// top level of the circular deque: controller plus datapath
// depends on cdq_pkg, cdq_ctrl and cdq_datapath
`timescale 1ns / 1ps
`default_nettype none

// fixed-depth double-ended queue of 32-bit words in a circular store. each
// request carries op (push back, pop back, push front, pop front) and a data
// word used by pushes only. every request gives exactly one result: the word
// removed on a successful pop (zero otherwise), a status (ok, full on push,
// empty on pop) and the number of entries held afterwards. a push when full or
// a pop when empty leaves the queue untouched. timing: a request is taken when
// in_valid is high and in_stall low; its result is presented on the next cycle
// and held until out_stall is low. in_stall is high for as long as a result
// sits in the output registers, including the cycle in which it is taken, so
// no new request is taken while an earlier result is still pending. the
// controller sets this by taking no new request until the pending result has
// gone; the registered read port of the store only places the popped word in
// the cycle after the request. the store is not cleared at reset; only words
// that were pushed can ever be popped, so no clearing pass is needed and the
// block takes requests straight out of reset.
module circular_double_ended_queue_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire cdq_pkg::in_item_t  in_item,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output cdq_pkg::out_item_t      out_item
);
  import cdq_pkg::*;

  // single accept command towards the datapath
  dp_cmd_t cmd;

  cdq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // indices, fill level and the store; result fields are registered here
  cdq_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_item  (in_item),
    .out_item (out_item)
  );

endmodule

`default_nettype wire

// ----- verif/tb_circular_double_ended_queue_unit.sv -----
// self-checking testbench for circular_double_ended_queue_unit
// depends on cdq_pkg and the rtl of the block; directed table then biased random requests
`timescale 1ns / 1ps

module tb_circular_double_ended_queue_unit;
  import cdq_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RANDOM_ITEMS = 800;
  localparam int PHASES       = 3;
  localparam int RUN_LEN      = 40;   // requests per push/pop bias segment
  localparam int HOLD_CYCLES  = 60;   // long receiver hold-off
  localparam int DRAIN_CYCLES = 8;
  localparam int STALL_LIMIT  = 600;  // cycles with no handshake before giving up

  // directed stimulus row: expected result typed in only where obvious
  typedef struct {
    in_item_t  req;
    bit        typed;
    out_item_t want;
  } stim_row_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  // shadow deque used to predict every result
  logic [WORD_W-1:0] shadow_mem [DEPTH];
  logic [IDX_W-1:0]  shadow_head;
  logic [IDX_W-1:0]  shadow_tail;
  int unsigned       shadow_fill;

  out_item_t   pending_results [$];
  stim_row_t   directed_rows [$];
  int unsigned mismatch_count = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_idle_pct  = 0;
  bit          hold_request   = 1'b0;
  int unsigned hold_left      = 0;
  int unsigned quiet_cycles   = 0;

  circular_double_ended_queue_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  always #CLK_HALF clk = ~clk;

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t ns: %s", $time, what);
    mismatch_count++;
  endtask

  // applies one request to the shadow deque and returns the result it gives
  function automatic out_item_t deque_apply(input in_item_t req);
    out_item_t r;
    r = '0;
    r.status = ST_OK;
    case (req.op)
      OP_PUSH_BACK, OP_PUSH_FRONT: begin
        if (shadow_fill >= DEPTH) begin
          r.status = ST_FULL;
        end else if (req.op == OP_PUSH_BACK) begin
          shadow_mem[shadow_tail] = req.data_in;
          shadow_tail = IDX_W'((shadow_tail + 1) % DEPTH);
          shadow_fill++;
        end else begin
          shadow_head = IDX_W'((shadow_head + DEPTH - 1) % DEPTH);
          shadow_mem[shadow_head] = req.data_in;
          shadow_fill++;
        end
      end
      default: begin
        if (shadow_fill == 0) begin
          r.status = ST_EMPTY;
        end else if (req.op == OP_POP_BACK) begin
          shadow_tail = IDX_W'((shadow_tail + DEPTH - 1) % DEPTH);
          r.data_out = shadow_mem[shadow_tail];
          shadow_fill--;
        end else begin
          r.data_out = shadow_mem[shadow_head];
          shadow_head = IDX_W'((shadow_head + 1) % DEPTH);
          shadow_fill--;
        end
      end
    endcase
    r.count = CNT_W'(shadow_fill);
    return r;
  endfunction

  task automatic add_row(input logic [1:0] op, input logic [WORD_W-1:0] word,
                         input bit typed, input logic [WORD_W-1:0] dout,
                         input logic [1:0] st, input int unsigned cnt);
    stim_row_t row;
    row.req.op       = op;
    row.req.data_in  = word;
    row.typed        = typed;
    row.want.data_out = dout;
    row.want.status   = st;
    row.want.count    = CNT_W'(cnt);
    directed_rows.push_back(row);
  endtask

  // random request; push_bias is the chance in percent of a push
  function automatic in_item_t random_request(input int unsigned push_bias);
    in_item_t req;
    bit       is_push;
    is_push = ($urandom_range(99) < push_bias);
    if ($urandom_range(1)) begin
      req.op = is_push ? OP_PUSH_BACK : OP_POP_BACK;
    end else begin
      req.op = is_push ? OP_PUSH_FRONT : OP_POP_FRONT;
    end
    case ($urandom_range(7))
      0: req.data_in = 32'h7fff_ffff;
      1: req.data_in = 32'h8000_0000;
      2: req.data_in = $urandom_range(1) ? 32'hffff_ffff : 32'h0000_0000;
      default: req.data_in = $urandom;
    endcase
    return req;
  endfunction

  // offers one request, waits for the handshake and records the expected result
  task automatic offer(input in_item_t req, input bit typed, input out_item_t want);
    out_item_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= req;
    do @(posedge clk); while (in_stall);
    predicted = deque_apply(req);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // receiver side: random stall, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // result checker: oldest expectation first, field by field
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result arrived with nothing expected");
      end else begin
        want = pending_results.pop_front();
        if (out_item.data_out !== want.data_out)
          report_mismatch($sformatf("data_out %h, expected %h",
                                    out_item.data_out, want.data_out));
        if (out_item.status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d",
                                    out_item.status, want.status));
        if (out_item.count !== want.count)
          report_mismatch($sformatf("count %0d, expected %0d",
                                    out_item.count, want.count));
      end
    end
  end

  // watchdog: any handshake on either side restarts the count
  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d quiet cycles", quiet_cycles);
      $display("circular_double_ended_queue_unit regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    out_item_t   none;
    int unsigned bias;
    none     = '0;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_item  <= '0;
    shadow_head = '0;
    shadow_tail = '0;
    shadow_fill = 0;

    // pops on an empty queue report empty and leave the count at zero
    add_row(OP_POP_BACK,   32'h1234_5678, 1, 32'h0, ST_EMPTY, 0);
    add_row(OP_POP_FRONT,  32'hffff_ffff, 1, 32'h0, ST_EMPTY, 0);
    // extremes of the word travel through both ends
    add_row(OP_PUSH_BACK,  32'h7fff_ffff, 1, 32'h0, ST_OK, 1);
    add_row(OP_PUSH_FRONT, 32'h8000_0000, 1, 32'h0, ST_OK, 2);
    add_row(OP_POP_BACK,   32'h0,         1, 32'h7fff_ffff, ST_OK, 1);
    add_row(OP_POP_FRONT,  32'h0,         1, 32'h8000_0000, ST_OK, 0);
    // fill to capacity from both ends, wrapping the front index
    for (int i = 0; i < DEPTH; i++) begin
      case (i % 4)
        0: add_row(OP_PUSH_BACK,  32'hffff_ffff, 0, 32'h0, ST_OK, 0);
        1: add_row(OP_PUSH_FRONT, 32'h0000_0000, 0, 32'h0, ST_OK, 0);
        2: add_row(OP_PUSH_BACK,  32'h5555_5555 ^ i, 0, 32'h0, ST_OK, 0);
        default: add_row(OP_PUSH_FRONT, 32'haaaa_aaaa ^ i, 0, 32'h0, ST_OK, 0);
      endcase
    end
    // pushes on a full queue report full and change nothing
    add_row(OP_PUSH_BACK,  32'hdead_beef, 1, 32'h0, ST_FULL, DEPTH);
    add_row(OP_PUSH_FRONT, 32'h0bad_f00d, 1, 32'h0, ST_FULL, DEPTH);
    add_row(OP_POP_FRONT,  32'h0,         0, 32'h0, ST_OK, 0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part runs with idling on both sides, heavier on the receiver
    send_idle_pct = 22;
    recv_idle_pct = 59;
    foreach (directed_rows[i])
      offer(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);

    // random part in three idling phases; bias flips between push-heavy,
    // pop-heavy and balanced so full and empty are both reached often
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 22;
          recv_idle_pct = 59;
        end
        1: begin
          send_idle_pct = 59;
          recv_idle_pct = 22;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          // receiver holds off while requests keep coming, so the block backs up
          hold_request = 1'b1;
        end
      endcase
      bias = 50;
      for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
        if (n % RUN_LEN == 0) begin
          case ($urandom_range(2))
            0: bias = 80;
            1: bias = 20;
            default: bias = 50;
          endcase
        end
        offer(random_request(bias), 0, none);
      end
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("circular_double_ended_queue_unit regression: pass");
    end else begin
      $display("circular_double_ended_queue_unit regression: fail");
    end
    $finish;
  end

endmodule
